// ===== rtl/rspd_pkg.sv =====
package rspd_pkg;

  localparam int unsigned AnimFramesDefault = 8;
  localparam int unsigned TimerBitsDefault = 14;

  localparam logic [2:0] ModeOpen = 3'd0;
  localparam logic [2:0] ModeBlank = 3'd1;
  localparam logic [2:0] ModeRelease = 3'd2;
  localparam logic [2:0] ModeStopped = 3'd3;
  localparam logic [2:0] ModeAnim = 3'd4;

  localparam logic [2:0] RegCirc = 3'd0;
  localparam logic [2:0] RegBlank = 3'd1;
  localparam logic [2:0] RegFrame = 3'd2;
  localparam logic [2:0] RegZero = 3'd3;
  localparam logic [2:0] RegStop = 3'd4;

  localparam logic [13:0] DashMask = 14'h0008;

  // Divider operation codes
  localparam logic OpSpeed = 1'b0;
  localparam logic OpAvg = 1'b1;

  typedef struct packed {
    logic start;
    logic [39:0] num;
    logic [39:0] den;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [39:0] quo;
  } div_rsp_t;

  function automatic logic [13:0] ones_glyph(input logic [3:0] d);
    logic [13:0] g;
    unique case (d)
      4'd0: g = 14'h3807;
      4'd1: g = 14'h2001;
      4'd2: g = 14'h180B;
      4'd3: g = 14'h300B;
      4'd4: g = 14'h200D;
      4'd5: g = 14'h300E;
      4'd6: g = 14'h380E;
      4'd7: g = 14'h2003;
      4'd8: g = 14'h380F;
      4'd9: g = 14'h200F;
      default: g = 14'h0000;
    endcase
    return g;
  endfunction

  function automatic logic [13:0] tens_glyph(input logic [3:0] d);
    logic [13:0] g;
    unique case (d)
      4'd0: g = 14'h0770;
      4'd1: g = 14'h0410;
      4'd2: g = 14'h03B0;
      4'd3: g = 14'h06B0;
      4'd4: g = 14'h04D0;
      4'd5: g = 14'h06E0;
      4'd6: g = 14'h07E0;
      4'd7: g = 14'h0430;
      4'd8: g = 14'h07F0;
      4'd9: g = 14'h04F0;
      default: g = 14'h0000;
    endcase
    return g;
  endfunction

  function automatic logic [13:0] spin_glyph(input logic [2:0] i);
    logic [13:0] g;
    unique case (i)
      3'd0: g = 14'h0001;
      3'd1: g = 14'h0002;
      3'd2: g = 14'h0020;
      3'd3: g = 14'h0040;
      3'd4: g = 14'h0100;
      3'd5: g = 14'h0200;
      3'd6: g = 14'h1000;
      default: g = 14'h2000;
    endcase
    return g;
  endfunction

  // Two-digit pattern for a speed, clipped at 99
  function automatic logic [13:0] speed_pattern(input logic [7:0] v);
    logic [6:0] d;
    logic [14:0] p;
    logic [3:0] t;
    logic [6:0] o;
    d = (v > 8'd99) ? 7'd99 : v[6:0];
    // Split into tens and ones; d*205 >> 11 equals d/10 below 100
    p = {8'd0, d} * 15'd205;
    t = p[14:11];
    o = d - ({3'd0, t} * 7'd10);
    if (d >= 7'd10) return tens_glyph(t) | ones_glyph(o[3:0]);
    return ones_glyph(o[3:0]);
  endfunction

  // Average divisor, clipped to 40 bits; beyond that the quotient is zero anyway
  function automatic logic [39:0] avg_den(input logic [31:0] s);
    logic [45:0] p;
    p = {14'd0, s} * 46'd10000;
    return (p[45:40] != 6'd0) ? 40'hFF_FFFF_FFFF : p[39:0];
  endfunction

endpackage

// ===== rtl/reed_speedometer.sv =====
// Reed-switch speedometer. Each transaction on the input channel is one
// millisecond reed sample; exactly one result transaction follows it. The
// result is valid after one 40-step pass of the shared restoring divider
// for the average, which is recomputed every tick, once the quotient is
// registered and the result presented. A closure that computes a speed
// runs a second pass first. The next sample is taken in the cycle after
// the result is accepted, so a stalled result holds off the next sample.
// The divider is the only arithmetic unit that iterates. Configuration
// writes are meant only for when the block is idle; the block itself does
// not enforce this.
module reed_speedometer #(
  parameter int unsigned ANIM_FRAMES = rspd_pkg::AnimFramesDefault,
  parameter int unsigned TIMER_BITS = rspd_pkg::TimerBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [13:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        reed_closed_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [13:0] segment_mask_o,
  output logic        led_on_o,
  output logic [7:0]  speed_kmh_o,
  output logic [7:0]  speed_mph_o,
  output logic [7:0]  max_speed_kmh_o,
  output logic [31:0] distance_mm_o,
  output logic [31:0] seconds_total_o,
  output logic [31:0] seconds_moving_o,
  output logic [7:0]  avg_speed_kmh_o,
  output logic        revolution_o,
  output logic        moving_o
);

  localparam logic [TIMER_BITS-1:0] TimerMax = '1;
  localparam int unsigned FrameW = 5;
  localparam logic [FrameW-1:0] FrameLast = FrameW'(ANIM_FRAMES);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StSpeed = 2'd1;
  localparam logic [1:0] StAvg = 2'd2;
  localparam logic [1:0] StOut = 2'd3;

  logic [11:0] circ_q;
  logic [7:0] blank_q, frame_q;
  logic [13:0] zero_q, stop_q;

  logic [1:0] st_q, st_d;
  logic [2:0] mode_q, mode_d;
  logic [TIMER_BITS-1:0] msr_q, msr_d;
  logic [9:0] mss_q, mss_d;
  logic [7:0] phase_q, phase_d;
  logic [FrameW-1:0] fidx_q, fidx_d;
  logic [13:0] seg_q, seg_d;
  logic [7:0] spd_q, spd_d, mph_q, mph_d, peak_q, peak_d, avg_q, avg_d;
  logic [31:0] dist_q, dist_d, tsec_q, tsec_d, msec_q, msec_d;
  logic rev_q, rev_d, oval_q, oval_d;

  rspd_pkg::div_req_t req;
  rspd_pkg::div_rsp_t rsp;

  rspd_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(req), .rsp_o(rsp));

  logic [7:0] blank_len, frame_len;
  logic [TIMER_BITS-1:0] msr_inc;
  logic [7:0] div_sat;
  logic [26:0] mph_scaled;
  logic [32:0] dist_sum;
  logic [7:0] ph_inc;
  logic [FrameW-1:0] fidx_inc;

  assign blank_len = (blank_q == 8'd0) ? 8'd1 : blank_q;
  assign frame_len = (frame_q == 8'd0) ? 8'd1 : frame_q;
  assign msr_inc = (msr_q < TimerMax) ? msr_q + 1'b1 : msr_q;
  assign div_sat = (rsp.quo > 40'd255) ? 8'd255 : rsp.quo[7:0];
  // v*62/100 as one reciprocal multiply, exact for every 8-bit v
  assign mph_scaled = {19'd0, div_sat} * 27'd325066;
  assign dist_sum = {1'b0, dist_q} + {21'd0, circ_q};
  assign ph_inc = phase_q + 8'd1;
  assign fidx_inc = fidx_q + 1'b1;

  assign in_stall_o = (st_q != StIdle) || oval_q;

  // Sequence one tick: update, optional speed division, average division
  always_comb begin
    st_d = st_q; mode_d = mode_q; msr_d = msr_q; mss_d = mss_q;
    phase_d = phase_q; fidx_d = fidx_q; seg_d = seg_q;
    spd_d = spd_q; mph_d = mph_q; peak_d = peak_q; avg_d = avg_q;
    dist_d = dist_q; tsec_d = tsec_q; msec_d = msec_q;
    rev_d = rev_q; oval_d = oval_q;
    req = '0;
    if (oval_q && !out_stall_i) oval_d = 1'b0;
    unique case (st_q)
      StIdle: begin
        if (in_valid_i && !in_stall_o) begin
          rev_d = 1'b0;
          msr_d = msr_inc;
          if (mss_q == 10'd999) begin
            mss_d = '0;
            if (tsec_q != '1) tsec_d = tsec_q + 32'd1;
            if (mode_q != rspd_pkg::ModeStopped && msec_q != '1) msec_d = msec_q + 32'd1;
          end else begin
            mss_d = mss_q + 10'd1;
          end
          st_d = StAvg;
          unique case (mode_q)
            rspd_pkg::ModeOpen: begin
              if (reed_closed_i) begin
                req.start = 1'b1;
                req.num = {28'd0, circ_q} * 40'd36;
                req.den = {{(40-TIMER_BITS){1'b0}}, (msr_inc == '0) ? {{(TIMER_BITS-1){1'b0}}, 1'b1} : msr_inc} * 40'd10;
                dist_d = dist_sum[32] ? 32'hFFFF_FFFF : dist_sum[31:0];
                msr_d = '0;
                phase_d = '0;
                mode_d = rspd_pkg::ModeBlank;
                rev_d = 1'b1;
                st_d = StSpeed;
              end else begin
                if ({{(20-TIMER_BITS){1'b0}}, msr_inc} == {6'd0, zero_q})
                  seg_d = rspd_pkg::ones_glyph(4'd0);
                if ({{(20-TIMER_BITS){1'b0}}, msr_inc} > {6'd0, stop_q}) begin
                  seg_d = rspd_pkg::DashMask;
                  spd_d = '0;
                  mph_d = '0;
                  mode_d = rspd_pkg::ModeStopped;
                end
              end
            end
            rspd_pkg::ModeBlank: begin
              phase_d = ph_inc;
              if (ph_inc >= blank_len) mode_d = rspd_pkg::ModeRelease;
            end
            rspd_pkg::ModeRelease: begin
              if (reed_closed_i) begin
                phase_d = '0;
                mode_d = rspd_pkg::ModeBlank;
              end else begin
                mode_d = rspd_pkg::ModeOpen;
              end
            end
            rspd_pkg::ModeStopped: begin
              if (reed_closed_i) begin
                mode_d = rspd_pkg::ModeAnim;
                phase_d = '0;
                fidx_d = '0;
                msr_d = '0;
                seg_d = rspd_pkg::spin_glyph(3'd0);
              end
            end
            default: begin
              phase_d = ph_inc;
              if (ph_inc >= frame_len) begin
                phase_d = '0;
                fidx_d = fidx_inc;
                if (fidx_inc >= FrameLast) begin
                  fidx_d = '0;
                  seg_d = rspd_pkg::ones_glyph(4'd0);
                  mode_d = rspd_pkg::ModeBlank;
                end else begin
                  seg_d = rspd_pkg::spin_glyph(fidx_inc[2:0]);
                end
              end
            end
          endcase
          if (st_d == StAvg) begin
            req.start = 1'b1;
            req.num = {8'd0, dist_d} * 40'd36;
            req.den = rspd_pkg::avg_den(msec_d);
          end
        end
      end
      StSpeed: begin
        if (rsp.done) begin
          spd_d = div_sat;
          mph_d = mph_scaled[26:19];
          if (div_sat > peak_q) peak_d = div_sat;
          seg_d = rspd_pkg::speed_pattern(div_sat);
          req.start = 1'b1;
          req.num = {8'd0, dist_q} * 40'd36;
          req.den = rspd_pkg::avg_den(msec_q);
          st_d = StAvg;
        end
      end
      StAvg: begin
        if (rsp.done) begin
          avg_d = (msec_q == '0) ? 8'd0 : div_sat;
          st_d = StOut;
        end
      end
      default: begin
        oval_d = 1'b1;
        st_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      circ_q <= 12'd2231; blank_q <= 8'd50; frame_q <= 8'd40;
      zero_q <= 14'd5000; stop_q <= 14'd10000;
      st_q <= StIdle; mode_q <= rspd_pkg::ModeStopped; msr_q <= '0; mss_q <= '0;
      phase_q <= '0; fidx_q <= '0; seg_q <= rspd_pkg::DashMask;
      spd_q <= '0; mph_q <= '0; peak_q <= '0; avg_q <= '0;
      dist_q <= '0; tsec_q <= '0; msec_q <= 32'd1;
      rev_q <= 1'b0; oval_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          rspd_pkg::RegCirc: circ_q <= cfg_data_i[11:0];
          rspd_pkg::RegBlank: blank_q <= cfg_data_i[7:0];
          rspd_pkg::RegFrame: frame_q <= cfg_data_i[7:0];
          rspd_pkg::RegZero: zero_q <= cfg_data_i;
          rspd_pkg::RegStop: stop_q <= cfg_data_i;
          default: ;
        endcase
      end
      st_q <= st_d; mode_q <= mode_d; msr_q <= msr_d; mss_q <= mss_d;
      phase_q <= phase_d; fidx_q <= fidx_d; seg_q <= seg_d;
      spd_q <= spd_d; mph_q <= mph_d; peak_q <= peak_d; avg_q <= avg_d;
      dist_q <= dist_d; tsec_q <= tsec_d; msec_q <= msec_d;
      rev_q <= rev_d; oval_q <= oval_d;
    end
  end

  assign out_valid_o = oval_q;
  assign segment_mask_o = seg_q;
  assign led_on_o = (mode_q == rspd_pkg::ModeBlank);
  assign speed_kmh_o = spd_q;
  assign speed_mph_o = mph_q;
  assign max_speed_kmh_o = peak_q;
  assign distance_mm_o = dist_q;
  assign seconds_total_o = tsec_q;
  assign seconds_moving_o = msec_q;
  assign avg_speed_kmh_o = avg_q;
  assign revolution_o = rev_q;
  assign moving_o = (mode_q != rspd_pkg::ModeStopped);

endmodule

// ===== rtl/rspd_div.sv =====
module rspd_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rspd_pkg::div_req_t  req_i,
  output rspd_pkg::div_rsp_t  rsp_o
);

  logic [39:0] rem_q, rem_d;
  logic [39:0] quo_q, quo_d;
  logic [39:0] den_q, den_d;
  logic [5:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic done_q, done_d;
  logic [40:0] trial;

  assign trial = {rem_q, quo_q[39]} - {1'b0, den_q};

  // Restoring division, one quotient bit per cycle
  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    den_d = den_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d = '0;
      quo_d = req_i.num;
      den_d = req_i.den;
      cnt_d = 6'd40;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[40]) begin
        rem_d = trial[39:0];
        quo_d = {quo_q[38:0], 1'b1};
      end else begin
        rem_d = {rem_q[38:0], quo_q[39]};
        quo_d = {quo_q[38:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo = quo_q;

endmodule
